>>> hdl/ibt_pkg.sv
// Shared types and codes for the interval booking table.
package ibt_pkg;

  // Sequencer states of the booking table.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // Result status codes.
  typedef logic [1:0] status_t;

  localparam status_t STATUS_BOOKED  = 2'd0;
  localparam status_t STATUS_OVERLAP = 2'd1;
  localparam status_t STATUS_INVALID = 2'd2;
  localparam status_t STATUS_FULL    = 2'd3;

  // Width of one stored interval: start and end side by side.
  localparam int unsigned BOUND_W = 32;
  localparam int unsigned SLOT_W  = 2 * BOUND_W;

endpackage

>>> hdl/interval_booking_table.sv
// Interval booking table: overlap check of booking requests against a stored table.
//
// Each request books the half-open interval [req_start, req_end). A request with a
// negative start or a start past its end is answered as invalid without a scan.
// Otherwise the stored intervals are read one per cycle from a table memory with one
// write port and one read port, and compared against the request by one shared signed
// compare unit. The answer is overlap, table full, or booked, in which case the
// interval is written into the next free slot. The block takes one request at a time
// and holds in_stall high while it works; a finished result waits in the output
// register, so the next request can be accepted before that result is taken. Reset
// empties the table at once through its fill count; no clearing pass is needed.
module interval_booking_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    req_start,
  input  logic signed [31:0]    req_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ibt_pkg::status_t      status
);
  import ibt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);

  state_t state;
  state_t state_next;

  logic signed [BOUND_W-1:0] req_start_q;
  logic signed [BOUND_W-1:0] req_end_q;
  logic                      req_bad;
  logic                      bad_in;
  logic                      in_accept;

  logic [CW-1:0]             used_count;
  logic [CW-1:0]             scan_idx;
  logic                      rd_vld;
  logic                      hit;

  logic [SLOT_W-1:0]         slot_mem [TABLE_DEPTH];
  logic [SLOT_W-1:0]         rd_data;
  logic signed [BOUND_W-1:0] rd_start;
  logic signed [BOUND_W-1:0] rd_end;

  logic                      rd_en;
  logic                      wr_en;
  logic                      overlap_now;
  logic                      scan_done;
  logic                      load_out;
  status_t                   res_status;

  // Request screening on the input ports.
  assign bad_in    = req_start[31] || (req_start > req_end);
  assign in_accept = in_valid && !in_stall;

  assign rd_start = rd_data[SLOT_W-1:BOUND_W];
  assign rd_end   = rd_data[BOUND_W-1:0];

  // The shared compare unit tests one stored interval per cycle.
  assign overlap_now = rd_vld && (rd_start < req_end_q) && (rd_end > req_start_q);

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = bad_in ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    rd_en     = 1'b0;
    scan_done = 1'b0;
    wr_en     = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SCAN: begin
        rd_en     = (scan_idx != used_count);
        scan_done = (scan_idx == used_count) && !rd_vld;
      end
      ST_DECIDE: begin
        wr_en = !req_bad && !hit && (used_count != DEPTH_CNT);
      end
      ST_FINISH: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_start_q <= req_start;
      req_end_q   <= req_end;
      req_bad     <= bad_in;
    end
  end

  // Scan pointer, read-valid flag and overlap flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      hit      <= 1'b0;
      scan_idx <= '0;
    end else if (in_accept) begin
      rd_vld   <= 1'b0;
      hit      <= 1'b0;
      scan_idx <= '0;
    end else begin
      rd_vld <= rd_en;
      if (rd_en) begin
        scan_idx <= scan_idx + CW'(1);
      end
      if (overlap_now) begin
        hit <= 1'b1;
      end
    end
  end

  // Table memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[used_count[AW-1:0]] <= {req_start_q, req_end_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= slot_mem[scan_idx[AW-1:0]];
    end
  end

  // Fill count of the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (wr_en) begin
      used_count <= used_count + CW'(1);
    end
  end

  // Result decision, in order of priority.
  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      if (req_bad) begin
        res_status <= STATUS_INVALID;
      end else if (hit) begin
        res_status <= STATUS_OVERLAP;
      end else if (used_count == DEPTH_CNT) begin
        res_status <= STATUS_FULL;
      end else begin
        res_status <= STATUS_BOOKED;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status <= res_status;
    end
  end

endmodule

>>> hdl/ibt_checker.sv
// Port-level checker for the interval booking table, with its bind statement.
module ibt_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input ibt_pkg::status_t      status
);
  import ibt_pkg::*;

  // A stalled result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");

  // The block is busy in the cycle after it takes a request.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A new result appears only as the block returns to idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result without finished request");

endmodule

bind interval_booking_table ibt_checker u_ibt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status)
);

>>> tb/testbench.sv
// Self-checking testbench for the interval booking table: random and directed booking requests.
`timescale 1ns / 100ps

import ibt_pkg::*;

// Scoreboard: mirrors the booked intervals and holds the statuses still owed by the block.
class booking_board;
  int unsigned        depth;
  logic signed [31:0] lo_q[$];
  logic signed [31:0] hi_q[$];
  status_t            due_q[$];
  int unsigned        mismatches;

  function new(int unsigned table_depth);
    depth = table_depth;
    mismatches = 0;
  endfunction

  // Work out the status of one accepted request and book it when it fits.
  function void note_request(logic signed [31:0] s, logic signed [31:0] e);
    status_t verdict;
    verdict = STATUS_BOOKED;
    if (s < 0 || s > e) begin
      verdict = STATUS_INVALID;
    end else begin
      foreach (lo_q[i]) begin
        if (lo_q[i] < e && hi_q[i] > s) verdict = STATUS_OVERLAP;
      end
      if (verdict == STATUS_BOOKED && lo_q.size() >= depth) verdict = STATUS_FULL;
      if (verdict == STATUS_BOOKED) begin
        lo_q.push_back(s);
        hi_q.push_back(e);
      end
    end
    due_q.push_back(verdict);
  endfunction

  // Print one line per mismatch, up to a cap, and count every one.
  task report_mismatch(string what);
    if (mismatches < 40) $display("ERROR: %s", what);
    mismatches++;
  endtask

  // Compare one accepted status with the oldest one owed.
  task check_status(status_t got);
    status_t want;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("status %0d arrived with no request pending", got));
    end else begin
      want = due_q.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf("status %0d, expected %0d", got, want));
      end
    end
  endtask

  // Any status still owed at the end is a failure.
  task finish_check();
    if (due_q.size() != 0) begin
      report_mismatch($sformatf("%0d statuses never arrived", due_q.size()));
    end
  endtask
endclass

module testbench;
  localparam int unsigned DEPTH       = 64;
  localparam int          LONG_HOLD   = 400;
  localparam int          QUIET_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] req_start = '0;
  logic [31:0] req_end = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  status_t     status;

  booking_board board;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_ticket = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  interval_booking_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_start (req_start),
    .req_end   (req_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status)
  );

  // Clock generation, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check accepted statuses and drive random or long stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) board.check_status(status);
      if (hold_seen != hold_ticket) begin
        hold_seen = hold_ticket;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, with an occasional gap first, and wait until it is taken.
  task automatic send_request(input logic [31:0] s, input logic [31:0] e);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_start <= s;
    req_end   <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(s, e);
  endtask

  // Stop offering and wait until every owed status has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk);
  endtask

  // Small signed offset around an interval edge.
  function automatic logic [31:0] jitter();
    return $urandom_range(6) - 3;
  endfunction

  // Random request: mostly probes around booked edges, plus fresh, invalid and raw noise.
  task automatic pick_request(output logic [31:0] s, output logic [31:0] e);
    int          kind;
    int          idx;
    logic [31:0] lo;
    logic [31:0] hi;
    kind = $urandom_range(99);
    if (kind < 10) begin
      s = $urandom;
      e = $urandom;
    end else if (kind < 22) begin
      // Invalid: negative start, or start past the end.
      if ($urandom_range(1)) begin
        s = $urandom | 32'h8000_0000;
        e = $urandom;
      end else begin
        s = $urandom & 32'h7FFF_FFFF;
        e = s - 1 - $urandom_range(1000);
      end
    end else if (kind < 35 || board.lo_q.size() == 0) begin
      // Fresh interval, mostly in a crowded window, sometimes anywhere.
      if ($urandom_range(7) == 0) begin
        s = $urandom & 32'h7FFF_FFFF;
        e = s + $urandom_range(3);
      end else begin
        s = $urandom_range(200000);
        e = ($urandom_range(7) == 0) ? s : s + $urandom_range(2000);
      end
    end else begin
      // Probe just around a booked interval.
      idx = $urandom_range(board.lo_q.size() - 1);
      lo = board.lo_q[idx];
      hi = board.hi_q[idx];
      case ($urandom_range(2))
        0: begin
          s = hi + jitter();
          e = s + $urandom_range(50);
        end
        1: begin
          e = lo + jitter();
          s = e - $urandom_range(50);
        end
        default: begin
          s = lo + jitter();
          e = hi + jitter();
        end
      endcase
    end
  endtask

  // One random phase with the given idle rates; a long result hold-off when hold_at is set.
  task automatic run_phase(input int send_pct, input int recv_pct, input int count,
                           input int hold_at);
    logic [31:0] s;
    logic [31:0] e;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    for (int k = 0; k < count; k++) begin
      if (hold_at != 0 && k == hold_at) hold_ticket <= hold_ticket + 1;
      pick_request(s, e);
      send_request(s, e);
    end
  endtask

  // Main sequence: reset, directed corners, three random phases, then drain and verdict.
  initial begin
    board = new(DEPTH);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Invalid requests at the extremes of both fields.
    send_request(32'h8000_0000, 32'd5);
    send_request(32'hFFFF_FFFF, 32'd10);
    send_request(32'd10, 32'd9);
    send_request(32'h7FFF_FFFF, 32'h8000_0000);
    // Booking, overlap, and intervals that only touch.
    send_request(32'd100, 32'd200);
    send_request(32'd150, 32'd160);
    send_request(32'd200, 32'd300);
    send_request(32'd50, 32'd100);
    send_request(32'd99, 32'd101);
    // Empty intervals are stored and still block requests that straddle them.
    send_request(32'd1000, 32'd1000);
    send_request(32'd990, 32'd1010);
    send_request(32'd5, 32'd5);
    send_request(32'd5, 32'd5);
    send_request(32'd0, 32'd0);
    send_request(32'd0, 32'd1);
    // Widest possible request and the top of the range.
    send_request(32'd0, 32'h7FFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(32'h7FFF_FFF5, 32'h7FFF_FFFF);
    send_request(32'h7FFF_FFFA, 32'h7FFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    wait_drained();

    run_phase(8, 71, 600, 0);
    wait_drained();
    run_phase(71, 8, 600, 0);
    wait_drained();
    run_phase(0, 0, 580, 100);
    wait_drained();
    repeat (80) @(posedge clk);

    board.finish_check();
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/ibt_pkg.sv
hdl/interval_booking_table.sv
hdl/ibt_checker.sv
tb/testbench.sv
